### sv/htsd_pkg.sv
// Package with the sizes, codes and handshake types shared by the Huffman tree decoder.
package htsd_pkg;

    localparam int NODES       = 512;
    localparam int STACK_DEPTH = 256;

    localparam int NODE_AW = $clog2(NODES);
    localparam int NFN_W   = $clog2(NODES + 1);
    localparam int STK_AW  = $clog2(STACK_DEPTH);
    localparam int TOP_W   = $clog2(STACK_DEPTH + 1);
    localparam int PAY_W   = (NODE_AW > 8) ? NODE_AW : 8;
    localparam int ENTRY_W = PAY_W + 1;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_BUILD  = 2'd1;
    localparam logic [1:0] PH_DECODE = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    localparam logic [1:0] ST_BYTE     = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_SINGLE   = 2'd2;

    localparam logic KIND_FORK = 1'b0;

    typedef struct packed {
        logic start_fork;
        logic load_byte;
        logic build_bit;
        logic dec_read;
        logic dec_eval;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic [1:0] phase;
        logic       can_step;
        logic       hold_valid;
    } t_status;

endpackage

### sv/htsd_ctrl.sv
// Controller that steps through the eight bits of each compressed byte.
module htsd_ctrl
    import htsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_kind,
    output logic    o_stall,
    input  t_status i_sts,
    output t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_EVAL  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0] r_state, n_state;
    logic [2:0] r_bit_cnt, n_bit_cnt;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_bit_cnt = r_bit_cnt;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_kind == KIND_FORK) begin
                        o_cmd.start_fork = 1'b1;
                    end else begin
                        o_cmd.load_byte = 1'b1;
                        n_bit_cnt       = 3'd0;
                        n_state         = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (i_sts.phase == PH_BUILD) begin
                    if (i_sts.can_step) begin
                        o_cmd.build_bit = 1'b1;
                        if (r_bit_cnt == 3'd7) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_bit_cnt = r_bit_cnt + 3'd1;
                        end
                    end
                end else if (i_sts.phase == PH_DECODE) begin
                    o_cmd.dec_read = 1'b1;
                    n_state        = S_EVAL;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_EVAL: begin
                if (i_sts.can_step) begin
                    o_cmd.dec_eval = 1'b1;
                    if (r_bit_cnt == 3'd7) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_bit_cnt = r_bit_cnt + 3'd1;
                        n_state   = S_RUN;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_sts.hold_valid) begin
                    n_state = S_IDLE;
                end else if (i_sts.can_step) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bit_cnt <= 3'd0;
        end else begin
            r_state   <= n_state;
            r_bit_cnt <= n_bit_cnt;
        end
    end

endmodule

### sv/htsd_datapath.sv
// Datapath with the node store, the parent stack, the tree walk and the result registers.
module htsd_datapath
    import htsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_sts,
    input  logic [7:0]  i_code_byte,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_status,
    output logic        o_end_of_data,
    output logic        o_last_in_run
);

    logic [ENTRY_W-1:0] r_node_mem [NODES];
    logic [NODE_AW-1:0] r_stack_mem [STACK_DEPTH];

    logic [31:0]        r_out_len;
    logic [1:0]         r_phase, n_phase;
    logic [7:0]         r_byte, n_byte;
    logic [TOP_W-1:0]   r_top, n_top;
    logic [NFN_W-1:0]   r_nfn, n_nfn;
    logic [3:0]         r_lbs, n_lbs;
    logic [7:0]         r_acc, n_acc;
    logic [NODE_AW-1:0] r_walk, n_walk;
    logic [NODE_AW-1:0] r_cur, n_cur;
    logic [NODE_AW-1:0] r_root_child, n_root_child;
    logic [NODE_AW-1:0] r_nxt, n_nxt;
    logic [31:0]        r_bytes_left, n_bytes_left;
    logic [ENTRY_W-1:0] r_node_rd;
    logic [NODE_AW-1:0] r_stk_rd;

    logic               r_hold_valid, n_hold_valid;
    logic [7:0]         r_hold_byte;
    logic [1:0]         r_hold_status;
    logic               r_hold_eod;
    logic               r_out_valid, n_out_valid;

    logic               bit_in;
    logic               node_we;
    logic [NODE_AW-1:0] node_waddr;
    logic [ENTRY_W-1:0] node_wdata;
    logic               stk_we;
    logic [TOP_W-1:0]   stk_rd_ptr;
    logic [NODE_AW-1:0] rd_addr;
    logic [NFN_W-1:0]   leaf_idx;
    logic [7:0]         leaf_val;
    logic               prod;
    logic [7:0]         prod_byte;
    logic [1:0]         prod_status;
    logic               prod_eod;
    logic               out_free;
    logic               out_load;

    assign bit_in     = r_byte[7];
    assign stk_rd_ptr = r_top - TOP_W'(1);
    assign rd_addr    = bit_in ? r_cur : r_walk + NODE_AW'(1);
    assign leaf_idx   = r_nfn - NFN_W'(1);
    assign leaf_val   = {r_acc[6:0], bit_in};
    assign out_free   = !r_out_valid || !i_out_stall;
    assign out_load   = (prod && r_hold_valid) || i_cmd.flush;

    always_comb begin
        n_phase      = r_phase;
        n_byte       = r_byte;
        n_top        = r_top;
        n_nfn        = r_nfn;
        n_lbs        = r_lbs;
        n_acc        = r_acc;
        n_walk       = r_walk;
        n_cur        = r_cur;
        n_root_child = r_root_child;
        n_nxt        = r_nxt;
        n_bytes_left = r_bytes_left;
        node_we      = 1'b0;
        node_waddr   = '0;
        node_wdata   = '0;
        stk_we       = 1'b0;
        prod         = 1'b0;
        prod_byte    = 8'd0;
        prod_status  = ST_BYTE;
        prod_eod     = 1'b0;

        if (i_cmd.start_fork) begin
            n_top        = '0;
            n_nfn        = '0;
            n_lbs        = 4'd0;
            n_acc        = 8'd0;
            n_walk       = '0;
            n_bytes_left = r_out_len;
            n_phase      = PH_BUILD;
        end

        if (i_cmd.load_byte) begin
            n_byte = i_code_byte;
        end

        if (i_cmd.build_bit) begin
            n_byte = {r_byte[6:0], 1'b0};
            if (r_lbs == 4'd0) begin
                if (r_nfn >= NFN_W'(NODES)) begin
                    prod        = 1'b1;
                    prod_status = ST_OVERFLOW;
                    n_phase     = PH_DONE;
                end else begin
                    n_nfn = r_nfn + NFN_W'(1);
                    if (bit_in) begin
                        n_lbs = 4'd1;
                        n_acc = 8'd0;
                    end else if (r_top >= TOP_W'(STACK_DEPTH)) begin
                        prod        = 1'b1;
                        prod_status = ST_OVERFLOW;
                        n_phase     = PH_DONE;
                    end else begin
                        node_we    = 1'b1;
                        node_waddr = r_nfn[NODE_AW-1:0];
                        node_wdata = '0;
                        stk_we     = 1'b1;
                        n_top      = r_top + TOP_W'(1);
                    end
                end
            end else begin
                n_acc = leaf_val;
                n_lbs = r_lbs + 4'd1;
                // The parent's bit-1 child is the node after this leaf, known from the tag bit on.
                if (r_lbs == 4'd1 && r_top != '0) begin
                    node_we    = 1'b1;
                    node_waddr = r_stk_rd;
                    node_wdata = {1'b0, PAY_W'(r_nfn[NODE_AW-1:0])};
                    if (r_stk_rd == '0) begin
                        n_root_child = r_nfn[NODE_AW-1:0];
                    end
                end
                if (r_lbs == 4'd8) begin
                    n_lbs      = 4'd0;
                    node_we    = 1'b1;
                    node_waddr = leaf_idx[NODE_AW-1:0];
                    node_wdata = {1'b1, PAY_W'(leaf_val)};
                    if (r_top != '0) begin
                        n_top = r_top - TOP_W'(1);
                    end else if (r_bytes_left == 32'd0) begin
                        n_phase = PH_DONE;
                    end else if (r_nfn == NFN_W'(1)) begin
                        prod        = 1'b1;
                        prod_status = ST_SINGLE;
                        n_phase     = PH_DONE;
                    end else begin
                        n_phase = PH_DECODE;
                        n_walk  = '0;
                        n_cur   = r_root_child;
                    end
                end
            end
        end

        if (i_cmd.dec_read) begin
            n_nxt = rd_addr;
        end

        if (i_cmd.dec_eval) begin
            n_byte = {r_byte[6:0], 1'b0};
            if (r_node_rd[ENTRY_W-1]) begin
                n_bytes_left = r_bytes_left - 32'd1;
                n_walk       = '0;
                n_cur        = r_root_child;
                prod         = 1'b1;
                prod_byte    = r_node_rd[7:0];
                prod_eod     = (r_bytes_left == 32'd1);
                if (r_bytes_left == 32'd1) begin
                    n_phase = PH_DONE;
                end
            end else begin
                n_walk = r_nxt;
                n_cur  = r_node_rd[NODE_AW-1:0];
            end
        end

        n_out_valid = r_out_valid && i_out_stall;
        if (out_load) begin
            n_out_valid = 1'b1;
        end
        n_hold_valid = r_hold_valid;
        if (i_cmd.flush) begin
            n_hold_valid = 1'b0;
        end
        if (prod) begin
            n_hold_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            r_node_mem[node_waddr] <= node_wdata;
        end
        if (i_cmd.dec_read) begin
            r_node_rd <= r_node_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack_mem[r_top[STK_AW-1:0]] <= r_nfn[NODE_AW-1:0];
        end
        r_stk_rd <= r_stack_mem[stk_rd_ptr[STK_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_len    <= 32'd0;
            r_phase      <= PH_IDLE;
            r_top        <= '0;
            r_nfn        <= '0;
            r_lbs        <= 4'd0;
            r_acc        <= 8'd0;
            r_walk       <= '0;
            r_cur        <= '0;
            r_root_child <= '0;
            r_nxt        <= '0;
            r_bytes_left <= 32'd0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_out_len <= i_cfg_data;
            end
            r_phase      <= n_phase;
            r_top        <= n_top;
            r_nfn        <= n_nfn;
            r_lbs        <= n_lbs;
            r_acc        <= n_acc;
            r_walk       <= n_walk;
            r_cur        <= n_cur;
            r_root_child <= n_root_child;
            r_nxt        <= n_nxt;
            r_bytes_left <= n_bytes_left;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        if (prod) begin
            r_hold_byte   <= prod_byte;
            r_hold_status <= prod_status;
            r_hold_eod    <= prod_eod;
        end
        if (out_load) begin
            o_out_byte    <= r_hold_byte;
            o_status      <= r_hold_status;
            o_end_of_data <= r_hold_eod;
            o_last_in_run <= i_cmd.flush;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_sts.phase      = r_phase;
    assign o_sts.can_step   = out_free || !r_hold_valid;
    assign o_sts.hold_valid = r_hold_valid;

endmodule

### sv/huffman_tree_stream_decoder_unit.sv
// Top level of the preorder Huffman tree stream decoder.
// A fork-start transaction leaves the input unstalled; a compressed byte is accepted, then
// each tree bit takes a build step, each decoded bit a read and an evaluate step (registered
// node store read), and a flush step closes the run; output stalls can hold build, evaluate and flush.
// A result waits until the next one of its run is formed or the run closes, then leaves.
// Reset is synchronous and active low; it clears control state but not the node store or stack.
module huffman_tree_stream_decoder_unit
    import htsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_code_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_status,
    output logic        o_end_of_data,
    output logic        o_last_in_run,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data
);

    t_cmd    cmd;
    t_status sts;

    htsd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    htsd_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_code_byte   (i_code_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_stall),
        .o_out_valid   (o_valid),
        .o_out_byte    (o_out_byte),
        .o_status      (o_status),
        .o_end_of_data (o_end_of_data),
        .o_last_in_run (o_last_in_run)
    );

endmodule

### sv/htsd_checker.sv
// Port-level checker for the Huffman tree stream decoder, bound to the top level.
module htsd_checker
    import htsd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_kind,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_out_byte,
    input logic [1:0]  o_status,
    input logic        o_end_of_data,
    input logic        o_last_in_run
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_status)
            && $stable(o_last_in_run))
        else $error("Stalled result transaction changed.");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_BYTE |-> o_out_byte == 8'd0 && !o_end_of_data)
        else $error("Error result carries data or end of data.");

    a_eod_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_data |-> o_last_in_run)
        else $error("Final byte of a fork is not the last result of its transaction.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == ST_BYTE || o_status == ST_OVERFLOW || o_status == ST_SINGLE)
        else $error("Result status code is out of range.");

    a_fork_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_kind == KIND_FORK |=> !o_stall)
        else $error("Fork start transaction left the input stalled.");

endmodule

bind huffman_tree_stream_decoder_unit htsd_checker u_htsd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_kind        (i_kind),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_out_byte    (o_out_byte),
    .o_status      (o_status),
    .o_end_of_data (o_end_of_data),
    .o_last_in_run (o_last_in_run)
);

### test/huffman_tree_stream_decoder_unit_test.sv
// Self-checking testbench for the preorder Huffman tree stream decoder.
`timescale 1ns / 100ps

module huffman_tree_stream_decoder_unit_test
    import htsd_pkg::*;
();

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 240;
    localparam int SETTLE_CYCLES = 40;
    localparam logic KIND_CODE = 1'b1;

    typedef struct packed {
        logic [7:0] value;
        logic [1:0] status;
        logic       eod;
        logic       last;
    } t_sym;

    typedef struct packed {
        logic               is_leaf;
        logic [PAY_W-1:0]   payload;
    } t_node;

    typedef enum logic [1:0] {ROW_CFG, ROW_FORK, ROW_BYTE} t_row_kind;

    typedef struct packed {
        t_row_kind   what;
        logic [31:0] arg;
        logic        typed;
        logic [1:0]  n_typed;
        t_sym        sym;
    } t_row;

    localparam t_sym NO_SYM = '0;

    localparam t_row SCRIPT [0:25] = '{
        '{ROW_BYTE, 32'h0000_00FF, 1'b1, 2'd0, NO_SYM},
        '{ROW_BYTE, 32'h0000_0000, 1'b1, 2'd0, NO_SYM},
        '{ROW_FORK, 32'h0000_00FF, 1'b1, 2'd0, NO_SYM},
        '{ROW_BYTE, 32'h0000_0080, 1'b1, 2'd0, NO_SYM},
        '{ROW_BYTE, 32'h0000_0000, 1'b1, 2'd0, NO_SYM},
        '{ROW_BYTE, 32'h0000_00FF, 1'b1, 2'd0, NO_SYM},
        '{ROW_CFG,  32'h0000_0003, 1'b0, 2'd0, NO_SYM},
        '{ROW_FORK, 32'h0000_0000, 1'b1, 2'd0, NO_SYM},
        '{ROW_BYTE, 32'h0000_00FF, 1'b1, 2'd0, NO_SYM},
        '{ROW_BYTE, 32'h0000_0080, 1'b1, 2'd1, t_sym'{8'h00, ST_SINGLE, 1'b0, 1'b1}},
        '{ROW_BYTE, 32'h0000_0055, 1'b1, 2'd0, NO_SYM},
        '{ROW_CFG,  32'hFFFF_FFFF, 1'b0, 2'd0, NO_SYM},
        '{ROW_FORK, 32'h0000_00A5, 1'b1, 2'd0, NO_SYM},
        '{ROW_BYTE, 32'h0000_0040, 1'b0, 2'd0, NO_SYM},
        '{ROW_BYTE, 32'h0000_003F, 1'b0, 2'd0, NO_SYM},
        '{ROW_BYTE, 32'h0000_00EA, 1'b0, 2'd0, NO_SYM},
        '{ROW_BYTE, 32'h0000_00FF, 1'b0, 2'd0, NO_SYM},
        '{ROW_BYTE, 32'h0000_0000, 1'b0, 2'd0, NO_SYM},
        '{ROW_CFG,  32'h0000_0001, 1'b0, 2'd0, NO_SYM},
        '{ROW_FORK, 32'h0000_005A, 1'b1, 2'd0, NO_SYM},
        '{ROW_BYTE, 32'h0000_0040, 1'b0, 2'd0, NO_SYM},
        '{ROW_BYTE, 32'h0000_003F, 1'b0, 2'd0, NO_SYM},
        '{ROW_BYTE, 32'h0000_00E0, 1'b0, 2'd0, NO_SYM},
        '{ROW_BYTE, 32'h0000_003C, 1'b1, 2'd0, NO_SYM},
        '{ROW_FORK, 32'h0000_0000, 1'b1, 2'd0, NO_SYM},
        '{ROW_BYTE, 32'h0000_0000, 1'b0, 2'd0, NO_SYM}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_kind = KIND_CODE;
    logic [7:0]  i_code_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_status;
    logic        o_end_of_data;
    logic        o_last_in_run;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_data = 32'h0;

    // Decoder state as predicted by the testbench.
    t_node              node_tbl [NODES];
    logic [NODE_AW-1:0] parent_stack [STACK_DEPTH];
    logic [TOP_W-1:0]   stk_ptr = '0;
    logic [NFN_W-1:0]   free_ptr = '0;
    logic [1:0]         dec_phase = PH_IDLE;
    logic [3:0]         tag_count = '0;
    logic [7:0]         leaf_acc = '0;
    logic [NODE_AW-1:0] cursor = '0;
    logic [31:0]        remaining = '0;
    logic [31:0]        out_len_reg = '0;

    t_sym step_syms [$];
    t_sym due_syms [$];
    logic code_bits [$];

    int src_gap_pct = 0;
    int rcv_gap_pct = 0;
    int items_sent = 0;
    int mismatches = 0;
    int cycles = 0;

    huffman_tree_stream_decoder_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_code_byte   (i_code_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_status      (o_status),
        .o_end_of_data (o_end_of_data),
        .o_last_in_run (o_last_in_run),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < rcv_gap_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void note_result(input logic [7:0] v, input logic [1:0] st,
                                        input logic eod);
        t_sym s;
        s.value = v;
        s.status = st;
        s.eod = eod;
        s.last = 1'b0;
        step_syms.push_back(s);
    endfunction

    function automatic void open_fork();
        foreach (node_tbl[i]) node_tbl[i] = '0;
        foreach (parent_stack[i]) parent_stack[i] = '0;
        stk_ptr = '0;
        free_ptr = '0;
        tag_count = '0;
        leaf_acc = '0;
        cursor = '0;
        remaining = out_len_reg;
        dec_phase = PH_BUILD;
    endfunction

    function automatic void decode_byte(input logic [7:0] cb);
        logic               b;
        logic [NODE_AW-1:0] idx;
        logic [NFN_W-1:0]   nxt;
        t_node              cur;
        t_node              hit;
        for (int k = 7; k >= 0; k--) begin
            b = cb[k];
            if (dec_phase == PH_BUILD) begin
                if (tag_count == 0) begin
                    if (free_ptr >= NODES) begin
                        note_result(8'h00, ST_OVERFLOW, 1'b0);
                        dec_phase = PH_DONE;
                        break;
                    end
                    idx = free_ptr[NODE_AW-1:0];
                    free_ptr++;
                    if (b) begin
                        tag_count = 4'd1;
                        leaf_acc = '0;
                    end else begin
                        if (stk_ptr >= STACK_DEPTH) begin
                            note_result(8'h00, ST_OVERFLOW, 1'b0);
                            dec_phase = PH_DONE;
                            break;
                        end
                        node_tbl[idx] = '0;
                        parent_stack[stk_ptr[STK_AW-1:0]] = idx;
                        stk_ptr++;
                    end
                end else begin
                    leaf_acc = {leaf_acc[6:0], b};
                    tag_count++;
                    if (tag_count == 4'd9) begin
                        tag_count = '0;
                        idx = NODE_AW'(free_ptr - 1'b1);
                        node_tbl[idx] = '{1'b1, PAY_W'(leaf_acc)};
                        if (stk_ptr != 0) begin
                            stk_ptr--;
                            node_tbl[parent_stack[stk_ptr[STK_AW-1:0]]] =
                                '{1'b0, PAY_W'(free_ptr)};
                        end else if (remaining == 0) begin
                            dec_phase = PH_DONE;
                            break;
                        end else if (free_ptr == 1) begin
                            note_result(8'h00, ST_SINGLE, 1'b0);
                            dec_phase = PH_DONE;
                            break;
                        end else begin
                            dec_phase = PH_DECODE;
                            cursor = '0;
                        end
                    end
                end
            end else if (dec_phase == PH_DECODE) begin
                cur = node_tbl[cursor];
                nxt = b ? NFN_W'(cur.payload) : NFN_W'(cursor) + 1'b1;
                if (nxt >= NODES) nxt = '0;
                hit = node_tbl[nxt[NODE_AW-1:0]];
                if (hit.is_leaf) begin
                    remaining--;
                    cursor = '0;
                    if (remaining == 0) begin
                        note_result(hit.payload[7:0], ST_BYTE, 1'b1);
                        dec_phase = PH_DONE;
                        break;
                    end
                    note_result(hit.payload[7:0], ST_BYTE, 1'b0);
                end else begin
                    cursor = nxt[NODE_AW-1:0];
                end
            end else begin
                break;
            end
        end
        if (step_syms.size() != 0) step_syms[step_syms.size() - 1].last = 1'b1;
    endfunction

    task automatic send_item(input logic kind, input logic [7:0] cb, input logic typed,
                             input logic [1:0] n_typed, input t_sym sym);
        @(negedge i_clk);
        while ($urandom_range(99) < src_gap_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_kind = kind;
        i_code_byte = cb;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        step_syms.delete();
        if (kind == KIND_FORK) open_fork();
        else decode_byte(cb);
        if (typed) begin
            if (n_typed != 0) due_syms.push_back(sym);
        end else begin
            foreach (step_syms[i]) due_syms.push_back(step_syms[i]);
        end
    endtask

    task automatic drain_block();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (due_syms.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [31:0] v);
        drain_block();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        out_len_reg = v;
    endtask

    function automatic void add_leaf(input logic [7:0] v);
        code_bits.push_back(1'b1);
        for (int k = 7; k >= 0; k--) code_bits.push_back(v[k]);
    endfunction

    function automatic void add_random_bits(input int n);
        for (int k = 0; k < n; k++) code_bits.push_back(1'($urandom));
    endfunction

    function automatic void grow_tree(input int depth, input int max_depth);
        if (depth > 0 && (depth >= max_depth || $urandom_range(99) < 40)) begin
            add_leaf(8'($urandom));
        end else begin
            code_bits.push_back(1'b0);
            grow_tree(depth + 1, max_depth);
            grow_tree(depth + 1, max_depth);
        end
    endfunction

    // Builds a tree that never closes, until either the node store or the stack runs out.
    function automatic void overfill_bits(input int leaf_pct);
        int depth_now;
        int nodes;
        depth_now = 0;
        nodes = 0;
        while (1'b1) begin
            if (nodes == NODES) begin
                code_bits.push_back(1'($urandom));
                break;
            end
            if (depth_now > 0 && $urandom_range(99) < leaf_pct) begin
                add_leaf(8'($urandom));
                depth_now--;
            end else begin
                code_bits.push_back(1'b0);
                if (depth_now == STACK_DEPTH) break;
                depth_now++;
            end
            nodes++;
        end
    endfunction

    // Keeps the stack just below full and alternates leaves and inner nodes until the store is full.
    function automatic void node_fill_bits();
        for (int k = 0; k < STACK_DEPTH - 1; k++) code_bits.push_back(1'b0);
        for (int k = STACK_DEPTH - 1; k < NODES; k += 2) begin
            add_leaf(8'($urandom));
            code_bits.push_back(1'b0);
        end
        code_bits.push_back(1'($urandom));
    endfunction

    task automatic send_bits();
        logic [7:0] cb;
        cb = '0;
        while (code_bits.size() != 0) begin
            for (int k = 0; k < 8; k++)
                cb = {cb[6:0], (code_bits.size() != 0) ? code_bits.pop_front() : 1'($urandom)};
            send_item(KIND_CODE, cb, 1'b0, 2'd0, NO_SYM);
        end
    endtask

    always @(posedge i_clk) begin
        t_sym got;
        t_sym want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_out_byte, o_status, o_end_of_data, o_last_in_run};
            if (due_syms.size() == 0) begin
                if (mismatches < 10)
                    $display("Unexpected result: byte %h status %0d eod %b last %b",
                             got.value, got.status, got.eod, got.last);
                mismatches++;
            end else begin
                want = due_syms.pop_front();
                if (got.value != want.value || got.status != want.status ||
                    got.eod != want.eod || got.last != want.last) begin
                    if (mismatches < 10)
                        $display("Mismatch: byte %h/%h status %0d/%0d eod %b/%b last %b/%b",
                                 want.value, got.value, want.status, got.status,
                                 want.eod, got.eod, want.last, got.last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int pick;
        int sel;
        int cut;
        int goal;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        src_gap_pct = 30;
        rcv_gap_pct = 47;
        foreach (SCRIPT[r]) begin
            if (SCRIPT[r].what == ROW_CFG)
                write_length(SCRIPT[r].arg);
            else
                send_item((SCRIPT[r].what == ROW_FORK) ? KIND_FORK : KIND_CODE,
                          SCRIPT[r].arg[7:0], SCRIPT[r].typed, SCRIPT[r].n_typed,
                          SCRIPT[r].sym);
        end

        for (int ph = 0; ph < 3; ph++) begin
            src_gap_pct = (ph == 0) ? 30 : (ph == 1) ? 47 : 0;
            rcv_gap_pct = (ph == 0) ? 47 : (ph == 1) ? 30 : 0;
            goal = items_sent + RANDOM_ITEMS / 3;
            while (items_sent < goal) begin
                pick = $urandom_range(99);
                if (pick < 25) begin
                    sel = $urandom_range(99);
                    if (sel < 10) write_length('0);
                    else if (sel < 20) write_length('1);
                    else if (sel < 80) write_length($urandom_range(40, 1));
                    else write_length($urandom);
                end else if (pick < 30) begin
                    drain_block();
                end
                send_item(KIND_FORK, 8'($urandom), 1'b0, 2'd0, NO_SYM);
                code_bits.delete();
                pick = $urandom_range(99);
                if (pick < 70) begin
                    grow_tree(0, $urandom_range(4, 1));
                    add_random_bits(8 * $urandom_range(10));
                end else if (pick < 78) begin
                    add_leaf(8'($urandom));
                    add_random_bits(8 * $urandom_range(3));
                end else if (pick < 86) begin
                    grow_tree(0, $urandom_range(4, 1));
                    cut = $urandom_range(code_bits.size() - 1);
                    while (code_bits.size() > cut) void'(code_bits.pop_back());
                end else if (pick < 94) begin
                    add_random_bits(8 * $urandom_range(8, 1));
                end else begin
                    overfill_bits(5);
                    add_random_bits(8 * $urandom_range(2));
                end
                send_bits();
            end
            if (ph == 2) begin
                send_item(KIND_FORK, 8'($urandom), 1'b0, 2'd0, NO_SYM);
                code_bits.delete();
                node_fill_bits();
                send_bits();
            end
            drain_block();
        end

        if (mismatches == 0 && due_syms.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
